// ----- hdl/multiplicity_shift_register_defines.svh -----
// Assertion macros for the multiplicity shift register.
// Each expects clk and arst_n in scope.
`ifndef MULTIPLICITY_SHIFT_REGISTER_DEFINES_SVH
`define MULTIPLICITY_SHIFT_REGISTER_DEFINES_SVH

`ifndef SYNTHESIS

`define MSR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define MSR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define MSR_ASSERT_IMP(lbl, ante, cons, msg)

`define MSR_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ----- hdl/msr_pkg.sv -----
package msr_pkg;

	localparam int BIN_W      = 9;
	localparam int WC_W       = 9;
	localparam int RD_W       = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam int PD_W       = 6;
	localparam int GATE_W     = 9;
	localparam int LONG_W     = 12;

	localparam logic [PD_W-1:0]   PD_RESET   = 6'd4;
	localparam logic [GATE_W-1:0] GATE_RESET = 9'd64;
	localparam logic [LONG_W-1:0] LONG_RESET = 12'd1024;

	localparam int RES_DEPTH = 3;
	localparam int RES_PTR_W = 2;

	typedef enum logic {
		REQ_TICK = 1'b0,
		REQ_READ = 1'b1
	} msr_req_t;

	typedef enum logic {
		HIST_RA = 1'b0,
		HIST_A  = 1'b1
	} msr_hist_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PREDELAY = 2'd0,
		CFG_GATE     = 2'd1,
		CFG_LONG     = 2'd2
	} msr_cfg_t;

	typedef struct packed {
		logic [WC_W-1:0] window_count;
		logic [RD_W-1:0] read_data;
	} msr_result_t;

endpackage

// ----- hdl/msr_if.sv -----
interface msr_in_if;
	import msr_pkg::*;

	logic             valid;
	logic             ready;
	logic             req_type;
	logic             pulse;
	logic             hist_select;
	logic [BIN_W-1:0] bin;

	modport source (output valid, output req_type, output pulse, output hist_select,
		output bin, input ready);
	modport sink (input valid, input req_type, input pulse, input hist_select,
		input bin, output ready);
endinterface

interface msr_out_if;
	import msr_pkg::*;

	logic            valid;
	logic            ready;
	logic [WC_W-1:0] window_count;
	logic [RD_W-1:0] read_data;

	modport source (output valid, output window_count, output read_data, input ready);
	modport sink (input valid, input window_count, input read_data, output ready);
endinterface

// ----- hdl/multiplicity_shift_register.sv -----
// channel   | role   | payload
// item      | sink   | req_type, pulse, hist_select, bin
// result    | source | window_count, read_data
// cfg_*     | write  | predelay_ticks, gate_ticks, long_delay_ticks
//
// One item per cycle while item.ready is high; its result is registered in s1, then written to the result queue.
// The window count comes from the gate cell chain, one shift per tick; reads use the histogram read-modify-write.
// After reset a sweep over all GATE_MAX+1 bins zeroes both histograms; item.ready is low meanwhile.
// A three-entry result queue absorbs stalls; item.ready drops when it could fill.
module multiplicity_shift_register #(
	parameter int GATE_MAX     = 256,
	parameter int PREDELAY_MAX = 64,
	parameter int LONG_MAX     = 4096,
	parameter int COUNT_BITS   = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [msr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [msr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	msr_in_if.sink                            item,
	msr_out_if.source                         result
);
	import msr_pkg::*;

`include "multiplicity_shift_register_defines.svh"

	localparam int BINS = GATE_MAX + 1;
	localparam int CW   = $clog2(BINS);
	localparam int XW   = (COUNT_BITS > RD_W) ? COUNT_BITS : RD_W + 1;

	logic [PD_W-1:0]   predelay_q;
	logic [GATE_W-1:0] gate_q;
	logic [LONG_W-1:0] long_q;

	logic              clr_busy_q;
	logic [CW-1:0]     clr_addr_q;

	logic              acc;
	logic              is_read;
	logic              tick;
	logic              bin_ok;
	logic [CW-1:0]     bin_addr;
	logic [CW-1:0]     occ_q;
	logic [CW-1:0]     occ_next;
	logic [CW-1:0]     ra_addr;
	logic [CW-1:0]     a_addr;

	logic              valid_s1;
	logic              read_s1;
	logic              pulse_s1;
	logic              sel_s1;
	logic              bin_ok_s1;
	logic [CW-1:0]     occ_s1;

	logic              due;
	logic              ra_bump;
	logic              a_bump;
	logic [COUNT_BITS-1:0] ra_val;
	logic [COUNT_BITS-1:0] a_val;
	logic [COUNT_BITS-1:0] hv;
	logic [XW-1:0]     hv_ext;
	logic [RD_W-1:0]   rd_sat;
	msr_result_t       res_s1;

	msr_result_t           res_q [RES_DEPTH];
	logic [RES_PTR_W-1:0]  wr_ptr_q;
	logic [RES_PTR_W-1:0]  rd_ptr_q;
	logic [RES_PTR_W-1:0]  cnt_q;
	logic                  pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			predelay_q <= PD_RESET;
			gate_q     <= GATE_RESET;
			long_q     <= LONG_RESET;
		end else if (cfg_we) begin
			case (msr_cfg_t'(cfg_index))
				CFG_PREDELAY: predelay_q <= cfg_wdata[PD_W-1:0];
				CFG_GATE:     gate_q     <= cfg_wdata[GATE_W-1:0];
				CFG_LONG:     long_q     <= cfg_wdata[LONG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + CW'(1);
			if (clr_addr_q == CW'(BINS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign item.ready = !clr_busy_q &&
		((3'(cnt_q) + 3'(valid_s1)) <= 3'(RES_DEPTH - 1));
	assign acc     = item.valid && item.ready;
	assign is_read = (item.req_type == REQ_READ);
	assign tick    = acc && !is_read;

	always_comb begin
		bin_ok   = (32'(item.bin) <= 32'(GATE_MAX));
		bin_addr = bin_ok ? CW'(item.bin) : '0;
		ra_addr  = is_read ? bin_addr : occ_q;
		a_addr   = is_read ? bin_addr : occ_next;
	end

	msr_window #(
		.GATE_MAX    (GATE_MAX),
		.PREDELAY_MAX(PREDELAY_MAX)
	) u_window (
		.clk           (clk),
		.arst_n        (arst_n),
		.tick          (tick),
		.pulse         (item.pulse),
		.predelay_ticks(predelay_q),
		.gate_ticks    (gate_q),
		.occ_next      (occ_next)
	);

	msr_long #(
		.LONG_MAX(LONG_MAX)
	) u_long (
		.clk             (clk),
		.arst_n          (arst_n),
		.tick            (tick),
		.pulse           (item.pulse),
		.long_delay_ticks(long_q),
		.due             (due)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (tick) begin
			occ_q <= occ_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		read_s1   <= is_read;
		pulse_s1  <= item.pulse;
		sel_s1    <= (item.hist_select == HIST_A);
		bin_ok_s1 <= bin_ok;
		occ_s1    <= is_read ? occ_q : occ_next;
	end

	assign ra_bump = valid_s1 && !read_s1 && pulse_s1;
	assign a_bump  = valid_s1 && !read_s1 && due;

	msr_hist #(
		.BINS      (BINS),
		.COUNT_BITS(COUNT_BITS)
	) u_hist_ra (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (clr_busy_q),
		.clr_addr(clr_addr_q),
		.rd_addr (ra_addr),
		.bump    (ra_bump),
		.value   (ra_val)
	);

	msr_hist #(
		.BINS      (BINS),
		.COUNT_BITS(COUNT_BITS)
	) u_hist_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (clr_busy_q),
		.clr_addr(clr_addr_q),
		.rd_addr (a_addr),
		.bump    (a_bump),
		.value   (a_val)
	);

	always_comb begin
		hv     = sel_s1 ? a_val : ra_val;
		hv_ext = XW'(hv);
		rd_sat = (|hv_ext[XW-1:RD_W]) ? '1 : hv_ext[RD_W-1:0];
		res_s1.window_count = WC_W'(occ_s1);
		res_s1.read_data    = (read_s1 && bin_ok_s1) ? rd_sat : '0;
	end

	assign pop          = result.valid && result.ready;
	assign result.valid = (cnt_q != '0);
	assign result.window_count = res_q[rd_ptr_q].window_count;
	assign result.read_data    = res_q[rd_ptr_q].read_data;

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_q[wr_ptr_q] <= res_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (valid_s1) begin
				wr_ptr_q <= (wr_ptr_q == RES_PTR_W'(RES_DEPTH - 1)) ? '0 :
					wr_ptr_q + RES_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == RES_PTR_W'(RES_DEPTH - 1)) ? '0 :
					rd_ptr_q + RES_PTR_W'(1);
			end
			cnt_q <= cnt_q + RES_PTR_W'(valid_s1) - RES_PTR_W'(pop);
		end
	end

	`MSR_ASSERT_IMP(a_queue_room, valid_s1 && !pop, cnt_q != RES_PTR_W'(RES_DEPTH), "result queue overflow")
	`MSR_ASSERT_IMP(a_no_item_in_clear, clr_busy_q, !valid_s1 && !acc, "item in flight during histogram clear")
	`MSR_ASSERT_NXT(a_ra_bump, tick && item.pulse, ra_bump, "pulse tick did not bump the R+A histogram")

endmodule

// ----- hdl/msr_gate_cell.sv -----
module msr_gate_cell #(
	parameter int CW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift,
	input  logic          ent,
	input  logic [CW-1:0] prev,
	output logic [CW-1:0] count
);

	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (shift) begin
			cnt_q <= prev + CW'(ent);
		end
	end

	assign count = cnt_q;

endmodule

// ----- hdl/msr_window.sv -----
module msr_window #(
	parameter int GATE_MAX     = 256,
	parameter int PREDELAY_MAX = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 tick,
	input  logic                                 pulse,
	input  logic [msr_pkg::PD_W-1:0]             predelay_ticks,
	input  logic [msr_pkg::GATE_W-1:0]           gate_ticks,
	output logic [$clog2(GATE_MAX+1)-1:0]        occ_next
);
	import msr_pkg::*;

	localparam int CW  = $clog2(GATE_MAX + 1);
	localparam int GI  = (GATE_MAX > 1) ? $clog2(GATE_MAX) : 1;
	localparam int PI  = (PREDELAY_MAX > 1) ? $clog2(PREDELAY_MAX) : 1;
	localparam int DWR = $clog2(PREDELAY_MAX + 1);
	localparam int DW  = (DWR > PD_W) ? DWR : PD_W;
	localparam int GWR = $clog2(GATE_MAX + 1);
	localparam int GW  = (GWR > GATE_W) ? GWR : GATE_W;

	logic [PREDELAY_MAX-1:0] pd_q;
	logic [CW-1:0]           pre_cnt [GATE_MAX];
	logic [DW-1:0]           d_ext;
	logic [DW-1:0]           d_sat;
	logic [DW-1:0]           d_m1;
	logic [GW-1:0]           g_ext;
	logic [GW-1:0]           g_sat;
	logic [GW-1:0]           g_m2;
	logic                    entering;
	logic [CW-1:0]           prior;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pd_q <= '0;
		end else if (tick) begin
			pd_q[0] <= pulse;
			for (int i = 1; i < PREDELAY_MAX; i++) begin
				pd_q[i] <= pd_q[i-1];
			end
		end
	end

	always_comb begin
		d_ext = DW'(predelay_ticks);
		d_sat = (d_ext > DW'(PREDELAY_MAX)) ? DW'(PREDELAY_MAX) : d_ext;
		d_m1  = d_sat - DW'(1);
		entering = (d_sat == '0) ? pulse : pd_q[d_m1[PI-1:0]];

		g_ext = GW'(gate_ticks);
		if (g_ext == '0) begin
			g_sat = GW'(1);
		end else if (g_ext > GW'(GATE_MAX)) begin
			g_sat = GW'(GATE_MAX);
		end else begin
			g_sat = g_ext;
		end
		g_m2  = g_sat - GW'(2);
		prior = (g_sat >= GW'(2)) ? pre_cnt[g_m2[GI-1:0]] : '0;
		occ_next = CW'(entering) + prior;
	end

	for (genvar i = 0; i < GATE_MAX; i++) begin : g_cell
		if (i == 0) begin : g_head
			msr_gate_cell #(.CW(CW)) u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.shift (tick),
				.ent   (entering),
				.prev  ('0),
				.count (pre_cnt[i])
			);
		end else begin : g_body
			msr_gate_cell #(.CW(CW)) u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.shift (tick),
				.ent   (entering),
				.prev  (pre_cnt[i-1]),
				.count (pre_cnt[i])
			);
		end
	end

endmodule

// ----- hdl/msr_long.sv -----
module msr_long #(
	parameter int LONG_MAX = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          tick,
	input  logic                          pulse,
	input  logic [msr_pkg::LONG_W-1:0]    long_delay_ticks,
	output logic                          due
);
	import msr_pkg::*;

	localparam int LA  = $clog2(LONG_MAX);
	localparam int AW  = $clog2(LONG_MAX + 1);
	localparam int SW  = (AW + 1 > LONG_W + 1) ? AW + 1 : LONG_W + 1;

	logic          mem_q [LONG_MAX];
	logic [LA-1:0] ptr_q;
	logic [AW-1:0] fill_q;
	logic          rd_s1;
	logic          ok_s1;
	logic [SW-1:0] a_sum;
	logic [SW-1:0] a_sat;
	logic [SW-1:0] ptr_ext;
	logic [SW-1:0] raddr_w;
	logic [LA-1:0] raddr;

	always_comb begin
		a_sum   = SW'(long_delay_ticks) + SW'(1);
		a_sat   = (a_sum > SW'(LONG_MAX)) ? SW'(LONG_MAX) : a_sum;
		ptr_ext = SW'(ptr_q);
		raddr_w = (ptr_ext >= a_sat) ? (ptr_ext - a_sat) : (ptr_ext + SW'(LONG_MAX) - a_sat);
		raddr   = raddr_w[LA-1:0];
	end

	always_ff @(posedge clk) begin
		rd_s1 <= mem_q[raddr];
		ok_s1 <= (SW'(fill_q) >= a_sat);
		if (tick) begin
			mem_q[ptr_q] <= pulse;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			fill_q <= '0;
		end else if (tick) begin
			ptr_q <= (ptr_q == LA'(LONG_MAX - 1)) ? '0 : ptr_q + LA'(1);
			if (fill_q != AW'(LONG_MAX)) begin
				fill_q <= fill_q + AW'(1);
			end
		end
	end

	assign due = rd_s1 & ok_s1;

endmodule

// ----- hdl/msr_hist.sv -----
module msr_hist #(
	parameter int BINS       = 257,
	parameter int COUNT_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        clr,
	input  logic [$clog2(BINS)-1:0]     clr_addr,
	input  logic [$clog2(BINS)-1:0]     rd_addr,
	input  logic                        bump,
	output logic [COUNT_BITS-1:0]       value
);

	localparam int AW = $clog2(BINS);

	logic [COUNT_BITS-1:0] mem_q [BINS];
	logic [COUNT_BITS-1:0] rd_s1;
	logic [AW-1:0]         addr_s1;
	logic                  byp_vld_q;
	logic [AW-1:0]         byp_addr_q;
	logic [COUNT_BITS-1:0] byp_data_q;
	logic                  we;
	logic [AW-1:0]         wa;
	logic [COUNT_BITS-1:0] wd;

	always_comb begin
		value = (byp_vld_q && (byp_addr_q == addr_s1)) ? byp_data_q : rd_s1;
		we    = clr | bump;
		wa    = clr ? clr_addr : addr_s1;
		if (clr) begin
			wd = '0;
		end else if (&value) begin
			wd = value;
		end else begin
			wd = value + COUNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		rd_s1      <= mem_q[rd_addr];
		addr_s1    <= rd_addr;
		byp_addr_q <= wa;
		byp_data_q <= wd;
		if (we) begin
			mem_q[wa] <= wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_vld_q <= 1'b0;
		end else begin
			byp_vld_q <= we;
		end
	end

endmodule

// ----- test/tb_multiplicity_shift_register.sv -----
`timescale 1ns / 100ps

module tb_multiplicity_shift_register;
	import msr_pkg::*;

	localparam int GATE_LEN_MAX = 256;
	localparam int PREDELAY_LEN = 64;
	localparam int LONG_LEN     = 4096;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 170;
	localparam int HOLD_CYCLES  = 80;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DIRECTED_N   = 21;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		msr_req_t         req;
		logic             pulse;
		msr_hist_t        hist;
		logic [BIN_W-1:0] bin;
		logic             known;
		msr_result_t      want;
	} stim_row_t;

	// rows after reset run with the reset register values
	localparam stim_row_t DIRECTED_ROWS [DIRECTED_N] = '{
		'{REQ_READ, 1'b0, HIST_RA, 9'd0,   1'b1, '{9'd0, 32'd0}},
		'{REQ_READ, 1'b1, HIST_A,  9'd256, 1'b1, '{9'd0, 32'd0}},
		'{REQ_READ, 1'b0, HIST_RA, 9'd511, 1'b1, '{9'd0, 32'd0}},
		'{REQ_READ, 1'b1, HIST_A,  9'd257, 1'b1, '{9'd0, 32'd0}},
		'{REQ_TICK, 1'b1, HIST_RA, 9'd0,   1'b1, '{9'd0, 32'd0}},
		'{REQ_READ, 1'b0, HIST_RA, 9'd0,   1'b1, '{9'd0, 32'd1}},
		'{REQ_TICK, 1'b1, HIST_RA, 9'd0,   1'b0, '{9'd0, 32'd0}},
		'{REQ_TICK, 1'b1, HIST_A,  9'd511, 1'b0, '{9'd0, 32'd0}},
		'{REQ_TICK, 1'b0, HIST_RA, 9'd0,   1'b0, '{9'd0, 32'd0}},
		'{REQ_TICK, 1'b1, HIST_RA, 9'd0,   1'b0, '{9'd0, 32'd0}},
		'{REQ_TICK, 1'b1, HIST_RA, 9'd0,   1'b0, '{9'd0, 32'd0}},
		'{REQ_TICK, 1'b1, HIST_RA, 9'd0,   1'b0, '{9'd0, 32'd0}},
		'{REQ_TICK, 1'b1, HIST_RA, 9'd0,   1'b0, '{9'd0, 32'd0}},
		'{REQ_TICK, 1'b1, HIST_RA, 9'd0,   1'b0, '{9'd0, 32'd0}},
		'{REQ_TICK, 1'b1, HIST_RA, 9'd0,   1'b0, '{9'd0, 32'd0}},
		'{REQ_READ, 1'b0, HIST_RA, 9'd1,   1'b0, '{9'd0, 32'd0}},
		'{REQ_READ, 1'b1, HIST_RA, 9'd2,   1'b0, '{9'd0, 32'd0}},
		'{REQ_READ, 1'b0, HIST_RA, 9'd3,   1'b0, '{9'd0, 32'd0}},
		'{REQ_READ, 1'b0, HIST_A,  9'd0,   1'b0, '{9'd0, 32'd0}},
		'{REQ_TICK, 1'b0, HIST_A,  9'd511, 1'b0, '{9'd0, 32'd0}},
		'{REQ_READ, 1'b0, HIST_RA, 9'd4,   1'b0, '{9'd0, 32'd0}}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	msr_in_if  item_ch ();
	msr_out_if result_ch ();

	multiplicity_shift_register #(
		.GATE_MAX(GATE_LEN_MAX),
		.PREDELAY_MAX(PREDELAY_LEN),
		.LONG_MAX(LONG_LEN),
		.COUNT_BITS(32)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.item(item_ch),
		.result(result_ch)
	);

	// shadow of the block's registers and shift lines
	logic [PD_W-1:0]   predelay_reg = PD_RESET;
	logic [GATE_W-1:0] gate_reg     = GATE_RESET;
	logic [LONG_W-1:0] long_reg     = LONG_RESET;

	bit          predelay_line [PREDELAY_LEN];
	bit          gate_line [GATE_LEN_MAX];
	bit          long_line [LONG_LEN];
	int          predelay_pos = 0;
	int          gate_pos     = 0;
	int          long_pos     = 0;
	int          occupancy    = 0;
	logic [31:0] coinc_hist [GATE_LEN_MAX + 1];
	logic [31:0] accid_hist [GATE_LEN_MAX + 1];

	msr_result_t pending_results [$];
	int          mismatches  = 0;
	int          cycle_count = 0;
	bit          calm        = 1'b0;
	bit          hold_req    = 1'b0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	function automatic msr_result_t model_item(input msr_req_t rq, input logic pl,
		input msr_hist_t hs, input logic [BIN_W-1:0] bn);
		msr_result_t res;
		int          span;
		int          lag;
		int          cnt;
		int          k;
		bit          entering;
		bit          due;
		res = '0;
		if (rq == REQ_READ) begin
			if (bn <= GATE_LEN_MAX)
				res.read_data = (hs == HIST_A) ? accid_hist[bn] : coinc_hist[bn];
		end else begin
			if (pl)
				coinc_hist[occupancy] = sat_inc(coinc_hist[occupancy]);

			if (predelay_reg == 0)
				entering = pl;
			else
				entering = predelay_line[(predelay_pos + PREDELAY_LEN
					- int'(predelay_reg)) % PREDELAY_LEN];
			predelay_line[predelay_pos] = pl;
			predelay_pos = (predelay_pos + 1) % PREDELAY_LEN;

			span = int'(gate_reg);
			if (span < 1)
				span = 1;
			if (span > GATE_LEN_MAX)
				span = GATE_LEN_MAX;
			gate_line[gate_pos] = entering;
			gate_pos = (gate_pos + 1) % GATE_LEN_MAX;
			cnt = 0;
			for (k = 1; k <= span; k++)
				cnt += gate_line[(gate_pos + GATE_LEN_MAX - k) % GATE_LEN_MAX];
			occupancy = cnt;

			lag = int'(long_reg) + 1;
			due = long_line[(long_pos + LONG_LEN - lag) % LONG_LEN];
			long_line[long_pos] = pl;
			long_pos = (long_pos + 1) % LONG_LEN;
			if (due)
				accid_hist[occupancy] = sat_inc(accid_hist[occupancy]);
		end
		res.window_count = occupancy[WC_W-1:0];
		return res;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_PREDELAY: predelay_reg = value[PD_W-1:0];
			CFG_GATE:     gate_reg     = value[GATE_W-1:0];
			CFG_LONG:     long_reg     = value[LONG_W-1:0];
			default:      ;
		endcase
	endtask

	task automatic set_config(input int pd, input int gate, input int lng);
		write_reg(CFG_PREDELAY, CFG_DATA_W'(pd));
		write_reg(CFG_GATE, CFG_DATA_W'(gate));
		write_reg(CFG_LONG, CFG_DATA_W'(lng));
	endtask

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_item(input msr_req_t rq, input logic pl, input msr_hist_t hs,
		input logic [BIN_W-1:0] bn, input logic known, input msr_result_t known_res);
		msr_result_t predicted;
		if (!calm && $urandom_range(0, 3) == 0) begin
			item_ch.valid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		item_ch.valid       = 1'b1;
		item_ch.req_type    = rq;
		item_ch.pulse       = pl;
		item_ch.hist_select = hs;
		item_ch.bin         = bn;
		do @(posedge clk); while (!item_ch.ready);
		predicted = model_item(rq, pl, hs, bn);
		pending_results.push_back(known ? known_res : predicted);
		@(negedge clk);
	endtask

	task automatic drain;
		item_ch.valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	initial begin : stimulus
		int               ph;
		int               n;
		int               density;
		logic [BIN_W-1:0] bn;
		stim_row_t        row;

		for (n = 0; n <= GATE_LEN_MAX; n++) begin
			coinc_hist[n] = '0;
			accid_hist[n] = '0;
		end
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = CFG_PREDELAY;
		cfg_wdata           = '0;
		item_ch.valid       = 1'b0;
		item_ch.req_type    = REQ_TICK;
		item_ch.pulse       = 1'b0;
		item_ch.hist_select = HIST_RA;
		item_ch.bin         = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (n = 0; n < DIRECTED_N; n++) begin
			row = DIRECTED_ROWS[n];
			send_item(row.req, row.pulse, row.hist, row.bin, row.known, row.want);
		end

		for (ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph)
				0: ;
				1: set_config(0, 0, 0);
				2: set_config(63, 511, 4095);
				3: set_config(0, 256, 7);
				4: set_config(1, 1, 1);
				5: begin
					set_config(17, 257, 300);
					write_reg(CFG_SPARE, 12'hFFF);
				end
				default: set_config($urandom_range(0, 63),
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 64),
					($urandom_range(0, 1) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 4095));
			endcase
			density = (ph == 3) ? 90 : $urandom_range(5, 95);
			if (ph == 6)
				hold_req = 1'b1;
			if (ph == PHASES - 1)
				calm = 1'b1;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 99) < 20) begin
					case ($urandom_range(0, 9))
						0:       bn = BIN_W'($urandom_range(GATE_LEN_MAX + 1, 511));
						1, 2:    bn = BIN_W'($urandom_range(0, GATE_LEN_MAX));
						default: bn = BIN_W'($urandom_range(0, occupancy + 3));
					endcase
					send_item(REQ_READ, 1'($urandom_range(0, 1)),
						$urandom_range(0, 1) ? HIST_A : HIST_RA, bn, 1'b0, '0);
				end else begin
					send_item(REQ_TICK, $urandom_range(0, 99) < density,
						$urandom_range(0, 1) ? HIST_A : HIST_RA,
						BIN_W'($urandom_range(0, 511)), 1'b0, '0);
				end
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin : result_sink
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				result_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				result_ch.ready = 1'b0;
				repeat ($urandom_range(0, 4)) @(negedge clk);
			end else begin
				result_ch.ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		msr_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: window_count %0d read_data %0d",
						result_ch.window_count, result_ch.read_data);
			end else begin
				want = pending_results.pop_front();
				if (result_ch.window_count !== want.window_count ||
					result_ch.read_data !== want.read_data) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: window_count %0d/%0d read_data %0d/%0d (exp/act)",
							want.window_count, result_ch.window_count,
							want.read_data, result_ch.read_data);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

endmodule
